// File: rtl/pidt_pkg.sv
package pidt_pkg;

  localparam int DataW = 16;
  localparam int LimitW = 14;
  localparam int DutyW = 8;

  localparam logic [15:0] NegThreshold = 16'h0FFF;
  // floor(x / 10) = (x * 52429) >> 19 for any 16-bit x
  localparam logic [15:0] TenRecip = 16'd52429;
  localparam int TenShift = 19;
  localparam int DutyDivisor = 10000;
  localparam int DutyQuotMax = 6;
  localparam logic [7:0] DutyReset = 8'd50;

  localparam logic signed [13:0] LowLimitReset = 14'sd10;
  localparam logic signed [13:0] HighLimitReset = 14'sd40;
  localparam logic [15:0] SetpointReset = 16'd100;
  localparam logic [15:0] PropGainReset = 16'd10;
  localparam logic [15:0] IntegGainReset = 16'd8;
  localparam logic [15:0] DerivGainReset = 16'd6;
  localparam logic [15:0] FeedbackReset = 16'd0;

  localparam int TenthsMax = 40959;

  typedef enum logic [2:0] {
    REG_LOW_LIMIT    = 3'd0,
    REG_HIGH_LIMIT   = 3'd1,
    REG_PID_SETPOINT = 3'd2,
    REG_PROP_GAIN    = 3'd3,
    REG_INTEG_GAIN   = 3'd4,
    REG_DERIV_GAIN   = 3'd5,
    REG_PID_FEEDBACK = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DECIDE,
    ST_PID_UPD,
    ST_PID_MAC,
    ST_DUTY,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } mac_term_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] raw_reading;
  } sample_t;

  typedef struct packed {
    logic        heater_level;
    logic        red_led;
    logic        green_led;
    logic [7:0]  duty_high;
    logic [15:0] temp_tenths;
    logic        negative;
  } result_t;

  typedef struct packed {
    logic       tick;
    logic [7:0] duty;
  } pwm_ctrl_t;

  // quotient of a 16-bit value by the duty divisor, at most six
  function automatic logic [2:0] duty_quot(input logic [15:0] r);
    logic [2:0] q;
    q = '0;
    for (int k = 1; k <= DutyQuotMax; k++) begin
      if ({1'b0, r} >= 17'(k * DutyDivisor)) q = 3'(k);
    end
    return q;
  endfunction

endpackage

// File: rtl/pidt_stream_if.sv
interface pidt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pidt_pwm_gen.sv
module pidt_pwm_gen #(
  parameter int PWM_PERIOD = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  pidt_pkg::pwm_ctrl_t ctrl,
  output logic               heater
);
  localparam logic [7:0] Period = 8'(PWM_PERIOD);

  logic [7:0] tick_count;
  logic [7:0] tick_next;

  assign tick_next = tick_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      heater <= 1'b1;
    end else if (ctrl.tick) begin
      priority if (tick_next <= ctrl.duty) begin
        tick_count <= tick_next;
        heater <= 1'b0;
      end else if (tick_next <= Period) begin
        tick_count <= tick_next;
        heater <= 1'b1;
      end else begin
        // end of period, pin held
        tick_count <= '0;
      end
    end
  end
endmodule

// File: rtl/pid_thermostat_pwm_drive.sv
// path from input transfer to result valid: a sample without a pid run goes through conv,
// decide and done; near a band edge it adds the pid updates (one state update per cycle), one
// multiplier pass per pid term and a duty step; a pwm tick goes straight to done
// one item at a time on the shared 16x16 multiplier: a new transfer is taken only once the
// last item has left done, while an earlier result may still wait
// synchronous active-high reset restores the register defaults, duty 50, all pins high
module pid_thermostat_pwm_drive #(
  parameter int PID_ITERATIONS = 10,
  parameter int PWM_PERIOD = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  pidt_stream_if.sink   sample,
  pidt_stream_if.source result
);
  localparam int IterW = (PID_ITERATIONS > 1) ? $clog2(PID_ITERATIONS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(PID_ITERATIONS - 1);
  localparam logic [7:0] Period = 8'(PWM_PERIOD);

  // configuration
  logic signed [13:0] low_limit;
  logic signed [13:0] high_limit;
  logic [15:0] pid_setpoint;
  logic [15:0] prop_gain;
  logic [15:0] integ_gain;
  logic [15:0] deriv_gain;
  logic [15:0] pid_feedback;

  pidt_pkg::state_t state, state_next;

  logic [15:0] error_sum;
  logic [15:0] last_err;
  logic [15:0] prev_err;
  logic [15:0] deriv;
  logic [15:0] acc;
  logic [IterW-1:0] iter;
  pidt_pkg::mac_term_t term;
  logic [7:0] duty_count;
  logic red_pin;
  logic green_pin;
  logic hot_side;
  logic [15:0] tenths;
  logic neg;
  logic [11:0] deg;

  logic in_xfer;
  logic load_out;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] product;
  logic [15:0] mag_raw;
  logic [15:0] mag;
  logic [18:0] mag_x5;
  logic signed [14:0] deg_s;
  logic signed [14:0] low_s;
  logic signed [14:0] high_s;
  logic is_cold;
  logic is_hot;
  logic far_cold;
  logic far_hot;
  logic run_pid;
  logic [15:0] err_now;
  logic [7:0] quot;
  logic heater_pin;
  pidt_pkg::pwm_ctrl_t pwm_ctrl;

  assign in_xfer = sample.valid && sample.ready;

  // sample front end
  assign mag_raw = sample.data.raw_reading;
  assign mag = (mag_raw >= pidt_pkg::NegThreshold) ? (~mag_raw + 16'd1) : mag_raw;
  assign mag_x5 = {1'b0, mag, 2'b00} + {3'b000, mag};

  // band decision
  assign deg_s = $signed({3'b000, deg});
  assign low_s = 15'(low_limit);
  assign high_s = 15'(high_limit);
  assign is_cold = low_s > deg_s;
  assign is_hot = !is_cold && (high_s <= deg_s);
  assign far_cold = (low_s - deg_s) > 15'sd1;
  assign far_hot = deg_s > high_s;
  assign run_pid = (is_cold && !far_cold) || (is_hot && !far_hot);

  assign err_now = pid_setpoint - pid_feedback;
  assign product = mul_a * mul_b;
  assign quot = {5'b00000, pidt_pkg::duty_quot(acc)};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pidt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = sample.data.opcode ? pidt_pkg::ST_DONE : pidt_pkg::ST_CONV;
        end
      end
      pidt_pkg::ST_CONV: state_next = pidt_pkg::ST_DECIDE;
      pidt_pkg::ST_DECIDE: begin
        state_next = run_pid ? pidt_pkg::ST_PID_UPD : pidt_pkg::ST_DONE;
      end
      pidt_pkg::ST_PID_UPD: begin
        if (iter == IterLast) state_next = pidt_pkg::ST_PID_MAC;
      end
      pidt_pkg::ST_PID_MAC: begin
        if (term == pidt_pkg::TERM_D) state_next = pidt_pkg::ST_DUTY;
      end
      pidt_pkg::ST_DUTY: state_next = pidt_pkg::ST_DONE;
      pidt_pkg::ST_DONE: begin
        if (load_out) state_next = pidt_pkg::ST_IDLE;
      end
      default: state_next = pidt_pkg::ST_IDLE;
    endcase
  end

  // control outputs and shared multiplier operands
  always_comb begin
    sample.ready = (state == pidt_pkg::ST_IDLE);
    load_out = (state == pidt_pkg::ST_DONE) && (!result.valid || result.ready);
    mul_a = tenths;
    mul_b = pidt_pkg::TenRecip;
    if (state == pidt_pkg::ST_PID_MAC) begin
      unique case (term)
        pidt_pkg::TERM_P: begin
          mul_a = prop_gain;
          mul_b = last_err;
        end
        pidt_pkg::TERM_I: begin
          mul_a = integ_gain;
          mul_b = error_sum;
        end
        pidt_pkg::TERM_D: begin
          mul_a = deriv_gain;
          mul_b = deriv;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign pwm_ctrl.tick = in_xfer && sample.data.opcode;
  assign pwm_ctrl.duty = duty_count;

  pidt_pwm_gen #(
    .PWM_PERIOD(PWM_PERIOD)
  ) u_pwm (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (pwm_ctrl),
    .heater(heater_pin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit <= pidt_pkg::LowLimitReset;
      high_limit <= pidt_pkg::HighLimitReset;
      pid_setpoint <= pidt_pkg::SetpointReset;
      prop_gain <= pidt_pkg::PropGainReset;
      integ_gain <= pidt_pkg::IntegGainReset;
      deriv_gain <= pidt_pkg::DerivGainReset;
      pid_feedback <= pidt_pkg::FeedbackReset;
    end else if (wr_en) begin
      unique case (wr_index)
        pidt_pkg::REG_LOW_LIMIT:    low_limit <= $signed(wr_data[13:0]);
        pidt_pkg::REG_HIGH_LIMIT:   high_limit <= $signed(wr_data[13:0]);
        pidt_pkg::REG_PID_SETPOINT: pid_setpoint <= wr_data;
        pidt_pkg::REG_PROP_GAIN:    prop_gain <= wr_data;
        pidt_pkg::REG_INTEG_GAIN:   integ_gain <= wr_data;
        pidt_pkg::REG_DERIV_GAIN:   deriv_gain <= wr_data;
        pidt_pkg::REG_PID_FEEDBACK: pid_feedback <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidt_pkg::ST_IDLE;
      error_sum <= '0;
      last_err <= '0;
      prev_err <= '0;
      duty_count <= pidt_pkg::DutyReset;
      red_pin <= 1'b1;
      green_pin <= 1'b1;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      unique case (state)
        pidt_pkg::ST_DECIDE: begin
          priority if (is_cold) begin
            red_pin <= 1'b0;
            green_pin <= 1'b1;
            if (far_cold) duty_count <= Period;
          end else if (is_hot) begin
            red_pin <= 1'b1;
            green_pin <= 1'b0;
            if (far_hot) duty_count <= '0;
          end else begin
            red_pin <= 1'b1;
            green_pin <= 1'b1;
          end
        end
        pidt_pkg::ST_PID_UPD: begin
          error_sum <= error_sum + err_now;
          prev_err <= last_err;
          last_err <= err_now;
        end
        pidt_pkg::ST_DUTY: begin
          if (hot_side) duty_count <= (duty_count < Period) ? quot : 8'd0;
          else duty_count <= (duty_count <= Period) ? quot : Period;
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (sample.data.opcode) begin
        tenths <= '0;
        neg <= 1'b0;
      end else begin
        tenths <= mag_x5[18:3];
        neg <= (mag_raw >= pidt_pkg::NegThreshold);
      end
    end
    if (state == pidt_pkg::ST_CONV) deg <= product[30:pidt_pkg::TenShift];
    if (state == pidt_pkg::ST_DECIDE) begin
      hot_side <= is_hot;
      iter <= '0;
    end
    if (state == pidt_pkg::ST_PID_UPD) begin
      iter <= iter + 1'b1;
      deriv <= last_err - prev_err;
      if (iter == IterLast) begin
        acc <= '0;
        term <= pidt_pkg::TERM_P;
      end
    end
    if (state == pidt_pkg::ST_PID_MAC) begin
      acc <= acc + product[15:0];
      unique case (term)
        pidt_pkg::TERM_P: term <= pidt_pkg::TERM_I;
        pidt_pkg::TERM_I: term <= pidt_pkg::TERM_D;
        default: term <= pidt_pkg::TERM_D;
      endcase
    end
    if (load_out) begin
      result.data.heater_level <= heater_pin;
      result.data.red_led <= red_pin;
      result.data.green_led <= green_pin;
      result.data.duty_high <= duty_count;
      result.data.temp_tenths <= tenths;
      result.data.negative <= neg;
    end
  end
endmodule

// File: rtl/pidt_checker.sv
module pidt_checker #(
  parameter int PWM_PERIOD = 100
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pidt_pkg::result_t out_data
);
  localparam logic [7:0] Period = 8'(PWM_PERIOD);

  // result held while stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one item in flight: busy right after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // never cold and hot at once
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.red_led || out_data.green_led))
    else $error("both indicators lit");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.duty_high <= Period || out_data.duty_high == pidt_pkg::DutyReset))
    else $error("duty beyond the pwm period");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.temp_tenths <= 16'(pidt_pkg::TenthsMax)))
    else $error("temperature out of range");
endmodule

bind pid_thermostat_pwm_drive pidt_checker #(
  .PWM_PERIOD(PWM_PERIOD)
) u_pidt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (sample.valid),
  .in_ready (sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_data (result.data)
);

// File: bench/pid_thermostat_pwm_drive_tb.sv
`timescale 1ns / 100ps

module pid_thermostat_pwm_drive_tb;

  localparam int PidIter = 10;
  localparam int PwmPeriod = 100;
  localparam logic OpSample = 1'b0;
  localparam logic OpTick = 1'b1;
  localparam logic [2:0] RegSpare = 3'd7;
  localparam int MaxDegrees = 3840;
  localparam int NumDirected = 22;
  localparam int NumPhases = 10;
  localparam int ItemsPerPhase = 50;
  localparam int HoldPhase = 7;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 30;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic              typed;
    pidt_pkg::sample_t item;
    pidt_pkg::result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [15:0] wr_data;

  pidt_stream_if #(.payload_t(pidt_pkg::sample_t)) sample_if ();
  pidt_stream_if #(.payload_t(pidt_pkg::result_t)) result_if ();

  pid_thermostat_pwm_drive #(
    .PID_ITERATIONS(PidIter),
    .PWM_PERIOD(PwmPeriod)
  ) dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .sample(sample_if),
    .result(result_if)
  );

  always #6 clk = ~clk;

  // thermostat copy: registers
  logic signed [13:0] lo_lim, hi_lim;
  logic [15:0] setpt, kp, ki, kd, fbk;
  // thermostat copy: state
  logic [15:0] err_sum, err_last, err_prev;
  logic [7:0]  duty, ticks;
  logic        heater_q, red_q, green_q;

  pidt_pkg::result_t pending_results[$];
  int bad_results = 0;
  int stall_cycles = 0;
  bit hold_req = 1'b0;
  bit tx_quiet = 1'b0;

  // directed rows: typed results only where they follow at a glance
  dir_row_t dir_rows [NumDirected] = '{
    '{1'b1, '{OpTick, 16'h5A5A}, '{1'b0, 1'b1, 1'b1, 8'd50, 16'd0, 1'b0}},
    '{1'b1, '{OpSample, 16'h0000}, '{1'b0, 1'b0, 1'b1, 8'd100, 16'd0, 1'b0}},
    '{1'b1, '{OpSample, 16'h0FFE}, '{1'b0, 1'b1, 1'b0, 8'd0, 16'd2558, 1'b0}},
    '{1'b1, '{OpSample, 16'h0FFF}, '{1'b0, 1'b1, 1'b0, 8'd0, 16'd38400, 1'b1}},
    '{1'b1, '{OpSample, 16'hFFFF}, '{1'b0, 1'b0, 1'b1, 8'd100, 16'd0, 1'b1}},
    '{1'b1, '{OpTick, 16'hA5A5}, '{1'b0, 1'b0, 1'b1, 8'd100, 16'd0, 1'b0}},
    '{1'b0, '{OpSample, 16'h8000}, '0},
    '{1'b0, '{OpSample, 16'd144}, '0},    // one below low limit
    '{1'b0, '{OpSample, 16'hFF70}, '0},   // same degree, negative
    '{1'b0, '{OpSample, 16'd160}, '0},
    '{1'b0, '{OpSample, 16'd624}, '0},
    '{1'b0, '{OpSample, 16'd640}, '0},    // on the high limit
    '{1'b0, '{OpSample, 16'hFD80}, '0},
    '{1'b0, '{OpSample, 16'd656}, '0},
    '{1'b0, '{OpSample, 16'd80}, '0},     // far cold, full duty
    '{1'b0, '{OpSample, 16'd640}, '0},    // high limit with full duty drops to zero
    '{1'b0, '{OpTick, 16'h0000}, '0},
    '{1'b0, '{OpTick, 16'hFFFF}, '0},
    '{1'b0, '{OpSample, 16'h0001}, '0},
    '{1'b0, '{OpSample, 16'h7FFF}, '0},
    '{1'b0, '{OpSample, 16'h1000}, '0},
    '{1'b0, '{OpSample, 16'hF000}, '0}
  };

  task automatic reset_thermostat();
    lo_lim = pidt_pkg::LowLimitReset;
    hi_lim = pidt_pkg::HighLimitReset;
    setpt = pidt_pkg::SetpointReset;
    kp = pidt_pkg::PropGainReset;
    ki = pidt_pkg::IntegGainReset;
    kd = pidt_pkg::DerivGainReset;
    fbk = pidt_pkg::FeedbackReset;
    err_sum = '0;
    err_last = '0;
    err_prev = '0;
    duty = pidt_pkg::DutyReset;
    ticks = '0;
    heater_q = 1'b1;
    red_q = 1'b1;
    green_q = 1'b1;
  endtask

  function automatic logic [15:0] run_pid();
    logic [15:0] e, d, acc;
    acc = '0;
    for (int i = 0; i < PidIter; i++) begin
      e = setpt - fbk;
      err_sum = err_sum + e;
      d = err_last - err_prev;
      err_prev = err_last;
      err_last = e;
      acc = kp * e + ki * err_sum + kd * d;
    end
    return acc;
  endfunction

  function automatic pidt_pkg::result_t predict_thermostat(pidt_pkg::sample_t s);
    pidt_pkg::result_t r;
    int mag, tenths, deg, lo, hi;
    logic neg;
    logic [15:0] pid_out;
    tenths = 0;
    neg = 1'b0;
    lo = lo_lim;
    hi = hi_lim;
    if (s.opcode == OpSample) begin
      mag = s.raw_reading;
      if (s.raw_reading >= pidt_pkg::NegThreshold) begin
        mag = 65536 - mag;
        neg = 1'b1;
      end
      tenths = (mag * 5) >> 3;
      deg = tenths / 10;
      if (lo > deg) begin
        red_q = 1'b0;
        green_q = 1'b1;
        if (lo - deg > 1) begin
          duty = 8'(PwmPeriod);
        end else begin
          pid_out = run_pid();
          if (duty <= PwmPeriod) duty = 8'(pid_out / pidt_pkg::DutyDivisor);
          else duty = 8'(PwmPeriod);
        end
      end else if (hi <= deg) begin
        red_q = 1'b1;
        green_q = 1'b0;
        if (deg - hi > 0) begin
          duty = '0;
        end else begin
          pid_out = run_pid();
          if (duty < PwmPeriod) duty = 8'(pid_out / pidt_pkg::DutyDivisor);
          else duty = '0;
        end
      end else begin
        red_q = 1'b1;
        green_q = 1'b1;
      end
    end else begin
      ticks = ticks + 8'd1;
      if (ticks <= duty) heater_q = 1'b0;
      else if (ticks <= PwmPeriod) heater_q = 1'b1;
      else ticks = '0;
    end
    r.heater_level = heater_q;
    r.red_led = red_q;
    r.green_led = green_q;
    r.duty_high = duty;
    r.temp_tenths = 16'(tenths);
    r.negative = neg;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // raw word whose reading lands on the given whole degree
  function automatic logic [15:0] raw_for_degrees(int deg);
    int tenths, mag;
    bit neg;
    if (deg < 0) deg = 0;
    if (deg > MaxDegrees) deg = MaxDegrees;
    tenths = deg * 10 + $urandom_range(0, 9);
    if (tenths > MaxDegrees * 10) tenths = MaxDegrees * 10;
    mag = (tenths * 8 + 4) / 5;
    neg = (mag >= pidt_pkg::NegThreshold) || (mag != 0 && $urandom_range(0, 1) == 1);
    return neg ? 16'(65536 - mag) : 16'(mag);
  endfunction

  function automatic pidt_pkg::sample_t random_item();
    pidt_pkg::sample_t s;
    int k, lo, hi;
    lo = lo_lim;
    hi = hi_lim;
    s.raw_reading = 16'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      s.opcode = OpTick;
    end else begin
      s.opcode = OpSample;
      // most samples aim at the band edges where the pid runs
      if ($urandom_range(0, 9) > 2) begin
        k = $urandom_range(0, 7);
        s.raw_reading = raw_for_degrees(k < 4 ? lo + k - 2 : hi + k - 5);
      end
    end
    return s;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      pidt_pkg::REG_LOW_LIMIT:    lo_lim = val[13:0];
      pidt_pkg::REG_HIGH_LIMIT:   hi_lim = val[13:0];
      pidt_pkg::REG_PID_SETPOINT: setpt = val;
      pidt_pkg::REG_PROP_GAIN:    kp = val;
      pidt_pkg::REG_INTEG_GAIN:   ki = val;
      pidt_pkg::REG_DERIV_GAIN:   kd = val;
      pidt_pkg::REG_PID_FEEDBACK: fbk = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(int lo, int hi, int sp, int p, int i, int d, int fb);
    // bits above the 14-bit limit field are don't-care
    write_reg(pidt_pkg::REG_LOW_LIMIT, {2'($urandom), 14'(lo)});
    write_reg(pidt_pkg::REG_HIGH_LIMIT, {2'($urandom), 14'(hi)});
    write_reg(pidt_pkg::REG_PID_SETPOINT, 16'(sp));
    write_reg(pidt_pkg::REG_PROP_GAIN, 16'(p));
    write_reg(pidt_pkg::REG_INTEG_GAIN, 16'(i));
    write_reg(pidt_pkg::REG_DERIV_GAIN, 16'(d));
    write_reg(pidt_pkg::REG_PID_FEEDBACK, 16'(fb));
    write_reg(RegSpare, 16'($urandom));
    wr_en <= 1'b0;
  endtask

  task automatic send_item(pidt_pkg::sample_t s, bit typed, pidt_pkg::result_t typed_res,
                           int gap);
    pidt_pkg::result_t model_res;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.data <= s;
    do @(posedge clk); while (!sample_if.ready);
    model_res = predict_thermostat(s);
    pending_results.push_back(typed ? typed_res : model_res);
  endtask

  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int lo, hi, sp, p, i, d, fb;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    sample_if.valid <= 1'b0;
    sample_if.data <= '0;
    reset_thermostat();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[n])
      send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].res, idle_gap());
    drain_results();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin lo = 10; hi = 40; sp = 100; p = 10; i = 8; d = 6; fb = 0; end
        1: begin lo = -1000; hi = 5000; sp = 0; p = 0; i = 0; d = 0; fb = 0; end
        2: begin lo = 5000; hi = 5000; sp = 65535; p = 65535; i = 65535; d = 65535;
                 fb = 65535; end
        3: begin lo = 0; hi = 0; sp = 12345; p = 65535; i = 65535; d = 65535; fb = 1; end
        4: begin lo = MaxDegrees; hi = MaxDegrees + 1; sp = 65535; p = 1; i = 2; d = 3;
                 fb = 0; end
        5: begin lo = 2000; hi = -1000; sp = 1; p = 1; i = 1; d = 1; fb = 65535; end
        default: begin
          lo = int'($urandom_range(0, 320)) - 20;
          hi = lo + int'($urandom_range(0, 40)) - 5;
          sp = $urandom_range(0, 65535);
          p = $urandom_range(0, 65535);
          i = $urandom_range(0, 65535);
          d = $urandom_range(0, 65535);
          fb = $urandom_range(0, 65535);
        end
      endcase
      program_regs(lo, hi, sp, p, i, d, fb);
      tx_quiet = ($urandom_range(0, 3) == 0);
      // long receiver hold while items keep coming, so the input backs up
      if (ph == HoldPhase) hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++)
        send_item(random_item(), 1'b0, '0, (tx_quiet || ph == HoldPhase) ? 0 : idle_gap());
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    int rx_stall;
    int quiet_left;
    bit rx_quiet;
    rx_stall = 0;
    quiet_left = 0;
    rx_quiet = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_left == 0) begin
        rx_quiet = ~rx_quiet;
        quiet_left = $urandom_range(50, 250);
      end else begin
        quiet_left--;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        rx_stall = HoldCycles;
      end else if (rx_stall == 0 && !rx_quiet) begin
        rx_stall = idle_gap();
      end
      if (rx_stall > 0) begin
        result_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    pidt_pkg::result_t want;
    pidt_pkg::result_t got;
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        wr_en || rst) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: result with nothing pending: duty %0d tenths %0d", $time,
                   got.duty_high, got.temp_tenths);
      end else begin
        want = pending_results.pop_front();
        if (got.heater_level !== want.heater_level || got.red_led !== want.red_led ||
            got.green_led !== want.green_led || got.duty_high !== want.duty_high ||
            got.temp_tenths !== want.temp_tenths || got.negative !== want.negative) begin
          bad_results++;
          if (bad_results <= 10)
            $display({"%0t: mismatch (exp/got) heater %0d/%0d red %0d/%0d green %0d/%0d",
                      " duty %0d/%0d tenths %0d/%0d neg %0d/%0d"}, $time,
                     want.heater_level, got.heater_level, want.red_led, got.red_led,
                     want.green_led, got.green_led, want.duty_high, got.duty_high,
                     want.temp_tenths, got.temp_tenths, want.negative, got.negative);
        end
      end
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/pidt_pkg.sv
rtl/pidt_stream_if.sv
rtl/pidt_pwm_gen.sv
rtl/pid_thermostat_pwm_drive.sv
rtl/pidt_checker.sv
bench/pid_thermostat_pwm_drive_tb.sv
